// ===== design/qrc_pkg.sv =====
// ============================================================================
// qrc_pkg
// Shared types, constants and the phase transition decoder of the
// quadrature range counter.
// ============================================================================
package qrc_pkg;

    // Default number of encoder channels
    localparam int CHANNELS_DEFAULT = 16;

    // Channel field width; only channels below 2**CH_W can ever be addressed
    localparam int CH_W = 4;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Direction codes (two-bit signed)
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [1:0] DIR_BACK = 2'sb11;

    // Phase pair, B in the high bit, A in the low bit
    typedef logic [1:0] phase_t;

    // Decoded work item passed from front to back
    typedef struct packed {
        logic signed [1:0] dir;
        logic signed [7:0] value;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
        logic        [6:0] step;
    } task_t;

    // Old/new phase pair to step direction
    function automatic logic signed [1:0] decode_step(input phase_t old_pair,
                                                      input phase_t new_pair);
        logic signed [1:0] d;
        d = DIR_NONE;
        unique case ({old_pair, new_pair})
            4'b0001, 4'b0111, 4'b1000, 4'b1110: d = DIR_BACK;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: d = DIR_FWD;
            default:                            d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

// ===== design/qrc_if.sv =====
// ============================================================================
// qrc_if
// Valid/ready channel interfaces for encoder samples and update results.
// ============================================================================

// Sample channel
interface qrc_in_if;
    logic              valid;
    logic              ready;
    logic        [3:0] channel;
    logic              pin_a;
    logic              pin_b;
    logic signed [7:0] value_in;
    logic signed [7:0] limit_low;
    logic signed [7:0] limit_high;
    logic        [6:0] step_size;

    modport source (
        output valid, channel, pin_a, pin_b, value_in, limit_low, limit_high,
               step_size,
        input  ready
    );
    modport sink (
        input  valid, channel, pin_a, pin_b, value_in, limit_low, limit_high,
               step_size,
        output ready
    );
endinterface

// Result channel
interface qrc_out_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] direction;
    logic signed [7:0] value_out;
    logic              changed;

    modport source (
        output valid, direction, value_out, changed,
        input  ready
    );
    modport sink (
        input  valid, direction, value_out, changed,
        output ready
    );
endinterface

// ===== design/quadrature_range_counter.sv =====
// ============================================================================
// quadrature_range_counter
// Multi-channel quadrature decoder that steps a bounded value per sample.
// ============================================================================
// Usage:
//   samples: one transfer per polled encoder sample (channel, A/B levels,
//   current value, limits and step). results: one transfer per sample, in
//   order, with the decoded direction, the clamped new value and a changed
//   flag. Samples for channels at or above CHANNELS decode as no movement
//   and leave the phase history untouched.
//   A sample accepted on samples is written into the queue and then into the
//   output register, and is presented on results when the output is free.
//   Throughput: one sample per cycle while the queue is not full; the front
//   lookup/decode is combinational and the back add/clamp is registered, with a two-entry queue between them.
//   samples.ready drops only when that queue is full, so a stalled receiver
//   holds the current result while two more samples are still taken.
//   Reset clears the per-channel phase history to 00, empties the queue and
//   drops results.valid; no clearing pass is needed.
// ============================================================================
module quadrature_range_counter #(
    parameter int CHANNELS = qrc_pkg::CHANNELS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    qrc_in_if.sink    samples,
    qrc_out_if.source results
);

    logic           push;
    logic           queue_full;
    qrc_pkg::task_t push_item;
    logic           pop;
    logic           head_valid;
    qrc_pkg::task_t head_item;

    qrc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    qrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    qrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .results    (results)
    );

endmodule

// ===== design/qrc_front.sv =====
// ============================================================================
// qrc_front
// Accepts samples, keeps the last phase pair per channel and decodes the
// step direction; pushes a decoded item into the queue.
// ============================================================================
module qrc_front #(
    parameter int CHANNELS = qrc_pkg::CHANNELS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    qrc_in_if.sink         samples,
    input  logic           queue_full,
    output logic           push,
    output qrc_pkg::task_t push_item
);

    // Only channels addressable by the 4-bit field need history
    localparam int DEPTH  = (CHANNELS < (1 << qrc_pkg::CH_W)) ? CHANNELS
                                                               : (1 << qrc_pkg::CH_W);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W  = IDX_W + qrc_pkg::CH_W;

    qrc_pkg::phase_t        hist_reg [DEPTH];
    logic [EXT_W-1:0]       ch_ext;
    logic [IDX_W-1:0]       idx;
    logic                   present;
    qrc_pkg::phase_t        now_pair;
    qrc_pkg::phase_t        old_pair;
    logic signed [1:0]      dir;

    // Channel lookup
    assign ch_ext   = {{IDX_W{1'b0}}, samples.channel};
    assign idx      = ch_ext[IDX_W-1:0];
    assign present  = (ch_ext < EXT_W'(DEPTH));
    assign now_pair = {samples.pin_b, samples.pin_a};
    assign old_pair = present ? hist_reg[idx] : '0;

    // Classify the transition
    always_comb
    begin
        dir = qrc_pkg::DIR_NONE;
        if (present)
        begin
            dir = qrc_pkg::decode_step(old_pair, now_pair);
        end
    end

    assign samples.ready    = !queue_full;
    assign push             = samples.valid && !queue_full;
    assign push_item.dir    = dir;
    assign push_item.value  = samples.value_in;
    assign push_item.lo     = samples.limit_low;
    assign push_item.hi     = samples.limit_high;
    assign push_item.step   = samples.step_size;

    // Phase history, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (push && present)
        begin
            hist_reg[idx] <= now_pair;
        end
    end

endmodule

// ===== design/qrc_queue.sv =====
// ============================================================================
// qrc_queue
// Short FIFO of decoded items between front and back.
// ============================================================================
module qrc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  qrc_pkg::task_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output qrc_pkg::task_t head_item
);

    localparam int PTR_W = (qrc_pkg::QUEUE_DEPTH > 1) ? $clog2(qrc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(qrc_pkg::QUEUE_DEPTH + 1);

    qrc_pkg::task_t     mem [qrc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(qrc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    // Pointer wrap
    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(qrc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    // Next pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(qrc_pkg::QUEUE_DEPTH))
        else $error("queue count over depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

// ===== design/qrc_back.sv =====
// ============================================================================
// qrc_back
// Applies the decoded step with bound clamping and holds the result in the
// output register.
// ============================================================================
module qrc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  qrc_pkg::task_t head_item,
    output logic           pop,
    qrc_out_if.source      results
);

    logic                   out_valid_reg;
    logic signed [1:0]      dir_reg;
    logic signed [7:0]      value_reg;
    logic                   changed_reg;

    logic signed [9:0]      v_w, lo_w, hi_w, step_w, sum_w, diff_w;
    logic signed [7:0]      value_next;
    logic                   changed_next;

    // Widened operands so the step never wraps
    assign v_w    = {{2{head_item.value[7]}}, head_item.value};
    assign lo_w   = {{2{head_item.lo[7]}}, head_item.lo};
    assign hi_w   = {{2{head_item.hi[7]}}, head_item.hi};
    assign step_w = {3'b000, head_item.step};
    assign sum_w  = v_w + step_w;
    assign diff_w = v_w - step_w;

    // Step and clamp toward the bound in the direction of movement
    always_comb
    begin
        value_next   = head_item.value;
        changed_next = 1'b0;
        if (head_item.dir == qrc_pkg::DIR_FWD && head_item.value < head_item.hi)
        begin
            value_next   = (sum_w > hi_w) ? head_item.hi : sum_w[7:0];
            changed_next = 1'b1;
        end
        else if (head_item.dir == qrc_pkg::DIR_BACK && head_item.value > head_item.lo)
        begin
            value_next   = (diff_w < lo_w) ? head_item.lo : diff_w[7:0];
            changed_next = 1'b1;
        end
    end

    assign pop = head_valid && (!out_valid_reg || results.ready);

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dir_reg     <= head_item.dir;
            value_reg   <= value_next;
            changed_reg <= changed_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.direction = dir_reg;
    assign results.value_out = value_reg;
    assign results.changed   = changed_reg;

`ifndef SYNTHESIS
    a_changed_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && changed_reg) |-> (dir_reg != qrc_pkg::DIR_NONE))
        else $error("change reported without a step");
`endif

endmodule

// ===== tb/sv/quadrature_range_counter_tb.sv =====
// ============================================================================
// quadrature_range_counter_tb
// Self-checking testbench for the quadrature range counter. A table of
// directed samples walks the decode table, bounds, zero steps and crossed
// limits. Random traffic follows: mostly Gray-code rotations per channel,
// with some invalid and repeated pairs mixed in. Every result transfer is
// compared with an in-order prediction. The sender runs in bursts, and the
// receiver stalls on patterns that include a long back-pressure hold.
// ============================================================================
module quadrature_range_counter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENC_CHANNELS   = qrc_pkg::CHANNELS_DEFAULT;
    localparam int RANDOM_SAMPLES = 530;
    localparam int HOLD_CYCLES    = 48;
    localparam int DRAIN_CYCLES   = 8;
    localparam int IDLE_LIMIT     = 2000;

    localparam logic signed [7:0] S8_MIN = -128;
    localparam logic signed [7:0] S8_MAX = 127;

    typedef struct packed {
        logic        [3:0] ch;
        logic              a;
        logic              b;
        logic signed [7:0] value;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
        logic        [6:0] step;
    } sample_t;

    typedef struct packed {
        logic signed [1:0] dir;
        logic signed [7:0] value;
        logic              changed;
    } update_t;

    typedef struct {
        sample_t smp;
        bit      fixed;
        update_t want;
    } vector_t;

    logic clk;
    logic rst_n;

    qrc_in_if  samples_if ();
    qrc_out_if results_if ();

    quadrature_range_counter #(
        .CHANNELS (ENC_CHANNELS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    // Predictor state and the store of pending updates
    qrc_pkg::phase_t phase_hist [ENC_CHANNELS];
    update_t         pending_updates [$];
    vector_t         directed_vectors [$];

    // Last pair sent per channel, used to build rotations
    qrc_pkg::phase_t sent_phase [16];

    // Side info that travels with the offered sample
    bit      offer_fixed;
    update_t offer_want;

    int      errors;
    int      burst_left;
    int      idle_cycles;
    bit      hold_req;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Expected update for one accepted sample; advances the phase history
    function automatic update_t predict_update(input sample_t s);
        update_t         u;
        qrc_pkg::phase_t now_pair;
        logic [3:0]      idx;
        int              sum;
        now_pair  = {s.b, s.a};
        u.dir     = qrc_pkg::DIR_NONE;
        u.value   = s.value;
        u.changed = 1'b0;
        if (s.ch < ENC_CHANNELS)
        begin
            idx = {phase_hist[s.ch], now_pair};
            case (idx)
                4'd1, 4'd7, 4'd8, 4'd14:  u.dir = qrc_pkg::DIR_BACK;
                4'd2, 4'd4, 4'd11, 4'd13: u.dir = qrc_pkg::DIR_FWD;
                default:                  u.dir = qrc_pkg::DIR_NONE;
            endcase
            phase_hist[s.ch] = now_pair;
        end
        if (u.dir == qrc_pkg::DIR_FWD && s.value < s.hi)
        begin
            sum = int'(s.value) + int'(s.step);
            if (sum > int'(s.hi))
                sum = int'(s.hi);
            u.value   = sum[7:0];
            u.changed = 1'b1;
        end
        else if (u.dir == qrc_pkg::DIR_BACK && s.value > s.lo)
        begin
            sum = int'(s.value) - int'(s.step);
            if (sum < int'(s.lo))
                sum = int'(s.lo);
            u.value   = sum[7:0];
            u.changed = 1'b1;
        end
        return u;
    endfunction

    function automatic void add_vec(input sample_t s, input bit fixed, input update_t u);
        vector_t v;
        v.smp   = s;
        v.fixed = fixed;
        v.want  = u;
        directed_vectors.push_back(v);
    endfunction

    // Random sample: mostly legal rotations, some repeats, double steps and noise
    function automatic sample_t random_sample();
        sample_t           s;
        qrc_pkg::phase_t   cur;
        qrc_pkg::phase_t   nxt;
        int                pick;
        logic signed [7:0] tmp;
        s.ch = 4'($urandom_range(0, 15));
        cur  = sent_phase[s.ch];
        pick = $urandom_range(0, 99);
        if (pick < 40)
            nxt = (cur == 2'd0) ? 2'd2 : (cur == 2'd2) ? 2'd3 : (cur == 2'd3) ? 2'd1 : 2'd0;
        else if (pick < 80)
            nxt = (cur == 2'd0) ? 2'd1 : (cur == 2'd1) ? 2'd3 : (cur == 2'd3) ? 2'd2 : 2'd0;
        else if (pick < 88)
            nxt = cur;
        else if (pick < 96)
            nxt = ~cur;
        else
            nxt = 2'($urandom_range(0, 3));
        sent_phase[s.ch] = nxt;
        s.a = nxt[0];
        s.b = nxt[1];

        // Limits mostly ordered, sometimes crossed
        s.lo = 8'($urandom_range(0, 255));
        s.hi = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8 && s.lo > s.hi)
        begin
            tmp  = s.lo;
            s.lo = s.hi;
            s.hi = tmp;
        end

        // Value near a bound often, so clamps and at-bound cases show up
        case ($urandom_range(0, 4))
            0:       s.value = s.lo;
            1:       s.value = s.hi;
            2:       s.value = s.hi - 8'($urandom_range(0, 6));
            3:       s.value = s.lo + 8'($urandom_range(0, 6));
            default: s.value = 8'($urandom_range(0, 255));
        endcase

        case ($urandom_range(0, 5))
            0:       s.step = ($urandom_range(0, 1) != 0) ? 7'd127 : 7'd0;
            1, 2:    s.step = 7'($urandom_range(1, 8));
            default: s.step = 7'($urandom_range(0, 127));
        endcase
        return s;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // Offer one sample, idling between bursts, and wait for its transfer
    task automatic send_sample(input sample_t s, input bit fixed, input update_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (hold_req || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                samples_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        samples_if.valid      <= 1'b1;
        samples_if.channel    <= s.ch;
        samples_if.pin_a      <= s.a;
        samples_if.pin_b      <= s.b;
        samples_if.value_in   <= s.value;
        samples_if.limit_low  <= s.lo;
        samples_if.limit_high <= s.hi;
        samples_if.step_size  <= s.step;
        offer_fixed           <= fixed;
        offer_want            <= want;
        do
            @(posedge clk);
        while (!samples_if.ready);
    endtask

    // Reset, stimulus and end of run
    initial
    begin : stimulus
        sample_t s;
        int      n;
        rst_n                 = 1'b0;
        samples_if.valid      = 1'b0;
        samples_if.channel    = '0;
        samples_if.pin_a      = 1'b0;
        samples_if.pin_b      = 1'b0;
        samples_if.value_in   = '0;
        samples_if.limit_low  = '0;
        samples_if.limit_high = '0;
        samples_if.step_size  = '0;
        offer_fixed           = 1'b0;
        offer_want            = '0;
        errors                = 0;
        burst_left            = 0;
        hold_req              = 1'b0;
        foreach (phase_hist[i])
            phase_hist[i] = 2'b00;
        foreach (sent_phase[i])
            sent_phase[i] = 2'b00;

        // Channel 0 walks forward and back through every legal transition
        add_vec('{4'd0, 1'b0, 1'b0, 8'sd5, -8'sd10, 8'sd10, 7'd3}, 1,
                '{qrc_pkg::DIR_NONE, 8'sd5, 1'b0});
        add_vec('{4'd0, 1'b0, 1'b1, 8'sd5, -8'sd10, 8'sd10, 7'd3}, 1,
                '{qrc_pkg::DIR_FWD, 8'sd8, 1'b1});
        add_vec('{4'd0, 1'b1, 1'b1, S8_MAX, S8_MIN, S8_MAX, 7'd1}, 1,
                '{qrc_pkg::DIR_FWD, S8_MAX, 1'b0});
        add_vec('{4'd0, 1'b1, 1'b0, 8'sd120, S8_MIN, S8_MAX, 7'd127}, 1,
                '{qrc_pkg::DIR_FWD, S8_MAX, 1'b1});
        add_vec('{4'd0, 1'b0, 1'b0, S8_MIN, S8_MIN, S8_MAX, 7'd127}, 1,
                '{qrc_pkg::DIR_FWD, -8'sd1, 1'b1});
        add_vec('{4'd0, 1'b1, 1'b0, S8_MIN, S8_MIN, S8_MAX, 7'd1}, 1,
                '{qrc_pkg::DIR_BACK, S8_MIN, 1'b0});
        add_vec('{4'd0, 1'b1, 1'b1, -8'sd120, S8_MIN, S8_MAX, 7'd127}, 1,
                '{qrc_pkg::DIR_BACK, S8_MIN, 1'b1});
        // zero step inside the range still counts as a change
        add_vec('{4'd0, 1'b0, 1'b1, 8'sd0, S8_MIN, S8_MAX, 7'd0}, 1,
                '{qrc_pkg::DIR_BACK, 8'sd0, 1'b1});
        add_vec('{4'd0, 1'b0, 1'b0, S8_MAX, S8_MIN, S8_MAX, 7'd127}, 1,
                '{qrc_pkg::DIR_BACK, 8'sd0, 1'b1});
        // double step, then an unchanged pair
        add_vec('{4'd0, 1'b1, 1'b1, 8'sd50, -8'sd10, 8'sd10, 7'd3}, 1,
                '{qrc_pkg::DIR_NONE, 8'sd50, 1'b0});
        add_vec('{4'd0, 1'b1, 1'b1, 8'sd50, -8'sd10, 8'sd10, 7'd3}, 1,
                '{qrc_pkg::DIR_NONE, 8'sd50, 1'b0});
        // crossed limits, both directions
        add_vec('{4'd1, 1'b0, 1'b1, 8'sd0, 8'sd20, 8'sd10, 7'd50}, 0, '0);
        add_vec('{4'd1, 1'b0, 1'b0, 8'sd30, 8'sd20, 8'sd10, 7'd5}, 0, '0);
        add_vec('{4'd2, 1'b0, 1'b1, 8'sd0, S8_MAX, S8_MIN, 7'd10}, 1,
                '{qrc_pkg::DIR_FWD, 8'sd0, 1'b0});
        add_vec('{4'd9, 1'b1, 1'b0, S8_MAX, S8_MAX, S8_MIN, 7'd127}, 1,
                '{qrc_pkg::DIR_BACK, S8_MAX, 1'b0});
        // top channel and other fields at their extremes
        add_vec('{4'd15, 1'b0, 1'b1, S8_MIN, S8_MIN, S8_MAX, 7'd127}, 0, '0);
        add_vec('{4'd15, 1'b1, 1'b0, 8'sd0, S8_MIN, S8_MAX, 7'd127}, 0, '0);
        add_vec('{4'd8, 1'b0, 1'b1, 8'sd126, S8_MIN, S8_MAX, 7'd127}, 0, '0);
        add_vec('{4'd10, 1'b0, 1'b1, -8'sd1, -8'sd5, 8'sd5, 7'd127}, 0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_vectors[i])
        begin
            s = directed_vectors[i].smp;
            sent_phase[s.ch] = {s.b, s.a};
            send_sample(s, directed_vectors[i].fixed, directed_vectors[i].want);
        end

        // Random traffic, with two back-pressure holds along the way
        for (n = 0; n < RANDOM_SAMPLES; n++)
        begin
            if (n == 150 || n == 380)
                hold_req = 1'b1;
            s = random_sample();
            send_sample(s, 1'b0, '0);
        end
        samples_if.valid <= 1'b0;
        // let the scoreboard log the last sample before draining
        @(posedge clk);

        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result side: stall modes per stretch, plus the long hold on request
    initial
    begin : receiver
        int mode;
        int span;
        int k;
        results_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 120);
            for (k = 0; k < span; k++)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    results_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0:       results_if.ready <= 1'b1;
                    1:       results_if.ready <= ($urandom_range(0, 9) < 6);
                    default: results_if.ready <= ((k % 5) >= 2);
                endcase
            end
        end
    end

    // Predict on each sample transfer, check each result transfer
    always @(posedge clk)
    begin : scoreboard
        sample_t got_s;
        update_t exp_u;
        if (rst_n && samples_if.valid && samples_if.ready)
        begin
            got_s = '{samples_if.channel, samples_if.pin_a, samples_if.pin_b,
                      samples_if.value_in, samples_if.limit_low, samples_if.limit_high,
                      samples_if.step_size};
            exp_u = predict_update(got_s);
            if (offer_fixed)
                exp_u = offer_want;
            pending_updates.push_back(exp_u);
        end
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_updates.size() == 0)
                flag_error("result transfer with no update pending");
            else
            begin
                exp_u = pending_updates.pop_front();
                if (results_if.direction !== exp_u.dir)
                    flag_error($sformatf("direction: expected %0d, got %0d",
                                         exp_u.dir, results_if.direction));
                if (results_if.value_out !== exp_u.value)
                    flag_error($sformatf("value_out: expected %0d, got %0d",
                                         exp_u.value, results_if.value_out));
                if (results_if.changed !== exp_u.changed)
                    flag_error($sformatf("changed: expected %0d, got %0d",
                                         exp_u.changed, results_if.changed));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
    end

endmodule

// ===== sim.f =====
design/qrc_pkg.sv
design/qrc_if.sv
design/qrc_front.sv
design/qrc_queue.sv
design/qrc_back.sv
design/quadrature_range_counter.sv
tb/sv/quadrature_range_counter_tb.sv
